>>> rtl/gdda_pkg.sv
package gdda_pkg;
	localparam int MAP_DIM_DEF   = 32;
	localparam int TILE_BITS_DEF = 8;
	localparam int DW            = 24;
	localparam logic [DW-1:0] SAT24 = 24'hFFFFFF;
	localparam int RESULT_CAP    = 64;
	localparam int CNT_W         = 6;

	localparam logic [2:0] KIND_EMPTY   = 3'd0;
	localparam logic [2:0] KIND_WALL    = 3'd1;
	localparam logic [2:0] KIND_DESTROY = 3'd2;
	localparam logic [2:0] KIND_SOLID   = 3'd3;
	localparam logic [2:0] KIND_EXIT    = 3'd4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture cast item
		logic div_start;  // start reciprocal unit
		logic div_step;   // one quotient bit
		logic mul_x;      // side_dist_x = frac*delta
		logic mul_y;
		logic advance;    // one DDA step
		logic rd_tile;    // register tile address read
		logic emit;       // drive result
		logic emit_last;
		logic clr_tile;   // destroyed tile -> 0
		logic wr_item;    // write item tile store
		logic clr_sweep;  // clearing pass write
	} gdda_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic outside;
		logic [1:0] tile_code; // 0 empty, 1 wall, 2 destructible, 3 other
	} gdda_stat_t;
endpackage

>>> rtl/gdda_ram.sv
module gdda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/gdda_datapath.sv
module gdda_datapath import gdda_pkg::*; #(
	parameter int MAP_DIM   = MAP_DIM_DEF,
	parameter int TILE_BITS = TILE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gdda_cmd_t           cmd,
	output gdda_stat_t          stat,
	input  logic [4:0]          tile_x,
	input  logic [4:0]          tile_y,
	input  logic [7:0]          tile_value,
	input  logic [20:0]         pos_x,
	input  logic [20:0]         pos_y,
	input  logic signed [17:0]  dir_x,
	input  logic signed [17:0]  dir_y,
	output logic signed [6:0]   cell_x,
	output logic signed [6:0]   cell_y,
	output logic [2:0]          hit_kind,
	output logic                last
);
	localparam int AW    = $clog2(MAP_DIM);
	localparam int IW    = 2 * AW;
	localparam int DEPTH = 1 << IW;

	logic signed [6:0] wcx_q, wcy_q;
	logic [DW-1:0]     sdx_q, sdy_q, dlx_q, dly_q;
	logic              negx_q, negy_q;
	logic [15:0]       fx_q, fy_q;
	logic [17:0]       ax_q, ay_q;

	// shared restoring divider: 2^32 / |dir|, one quotient bit a cycle,
	// x then y
	logic [33:0] rem_q;
	logic [32:0] quo_q;
	logic [5:0]  dcnt_q;
	logic        dsel_q;
	logic        ddone_q;
	logic [17:0] dvs;
	logic [33:0] rem_sh;
	logic [DW-1:0] qsat;

	// clearing pass counter
	logic [IW:0] sweep_q;

	assign dvs    = dsel_q ? ay_q : ax_q;
	assign rem_sh = {rem_q[32:0], 1'b0};
	assign qsat   = (dvs == '0 || quo_q[32:24] != '0) ? SAT24 : quo_q[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q  <= '0;
			dsel_q  <= 1'b0;
			ddone_q <= 1'b0;
		end else begin
			ddone_q <= 1'b0;
			if (cmd.div_start) begin
				dcnt_q <= '0;
				dsel_q <= 1'b0;
			end else if (cmd.div_step) begin
				if (dcnt_q == 6'd32) begin
					dcnt_q  <= '0;
					dsel_q  <= ~dsel_q;
					ddone_q <= dsel_q;
				end else begin
					dcnt_q <= dcnt_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= 34'd1;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (dcnt_q == 6'd32) begin
				if (dsel_q) dly_q <= qsat; else dlx_q <= qsat;
				rem_q <= 34'd1;
				quo_q <= '0;
			end else if (dvs != '0 && rem_sh >= {16'd0, dvs}) begin
				rem_q <= rem_sh - {16'd0, dvs};
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end
	// dividend 2^32: the remainder starts at one (the leading bit, whose
	// quotient bit is zero for |dir| > 1), then 32 zero bits shift in;
	// |dir| of one gives all ones and saturates.

	assign stat.div_done = ddone_q;

	// setup multiply: 17x24 one per cycle
	logic [16:0] frx, fry;
	logic [40:0] mprod;
	logic [DW-1:0] msat;
	assign frx   = negx_q ? {1'b0, fx_q} : 17'h10000 - {1'b0, fx_q};
	assign fry   = negy_q ? {1'b0, fy_q} : 17'h10000 - {1'b0, fy_q};
	assign mprod = cmd.mul_y ? fry * dly_q : frx * dlx_q;
	assign msat  = mprod[40] ? SAT24 : mprod[39:16];

	// DDA step
	logic          stepx;
	logic [DW:0]   sumx, sumy;
	logic signed [6:0] ncx, ncy;
	assign stepx = sdx_q < sdy_q;
	assign sumx  = {1'b0, sdx_q} + {1'b0, dlx_q};
	assign sumy  = {1'b0, sdy_q} + {1'b0, dly_q};
	assign ncx   = negx_q ? wcx_q - 7'sd1 : wcx_q + 7'sd1;
	assign ncy   = negy_q ? wcy_q - 7'sd1 : wcy_q + 7'sd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcx_q <= '0;
			wcy_q <= '0;
		end else if (cmd.load) begin
			wcx_q <= {2'b00, pos_x[20:16]};
			wcy_q <= {2'b00, pos_y[20:16]};
		end else if (cmd.advance) begin
			if (stepx) wcx_q <= ncx; else wcy_q <= ncy;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fx_q   <= pos_x[15:0];
			fy_q   <= pos_y[15:0];
			negx_q <= dir_x[17];
			negy_q <= dir_y[17];
			ax_q   <= dir_x[17] ? 18'(-dir_x) : dir_x;
			ay_q   <= dir_y[17] ? 18'(-dir_y) : dir_y;
		end
		if (cmd.mul_x) sdx_q <= msat;
		if (cmd.mul_y) sdy_q <= msat;
		if (cmd.advance) begin
			if (stepx) sdx_q <= sumx[DW] ? SAT24 : sumx[DW-1:0];
			else       sdy_q <= sumy[DW] ? SAT24 : sumy[DW-1:0];
		end
	end

	assign stat.outside = wcx_q < 0 || wcx_q >= 7'(MAP_DIM) ||
		wcy_q < 0 || wcy_q >= 7'(MAP_DIM);

	// tile store
	logic            we;
	logic [IW-1:0]   waddr, raddr, caddr;
	logic [TILE_BITS-1:0] wdata, rdata;
	logic [1:0]      tcode;
	assign caddr = {wcy_q[AW-1:0], wcx_q[AW-1:0]};
	assign raddr = caddr;
	always_comb begin
		we    = 1'b0;
		waddr = caddr;
		wdata = '0;
		if (cmd.clr_sweep) begin
			we    = 1'b1;
			waddr = sweep_q[IW-1:0];
		end else if (cmd.wr_item) begin
			we    = (32'(tile_x) < MAP_DIM) && (32'(tile_y) < MAP_DIM);
			waddr = {tile_y[AW-1:0], tile_x[AW-1:0]};
			wdata = TILE_BITS'(tile_value);
		end else if (cmd.clr_tile) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sweep_q <= '0;
		else if (cmd.clr_sweep) sweep_q <= sweep_q + 1'b1;
	end

	gdda_ram #(.WIDTH(TILE_BITS), .DEPTH(DEPTH)) u_map (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		if (rdata == '0)       tcode = 2'd0;
		else if (rdata == 1)   tcode = 2'd1;
		else if (rdata == 2)   tcode = 2'd2;
		else                   tcode = 2'd3;
	end
	assign stat.tile_code = tcode;

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			cell_x <= wcx_q;
			cell_y <= wcy_q;
			last   <= cmd.emit_last;
			if (stat.outside) hit_kind <= KIND_EXIT;
			else begin
				case (stat.tile_code)
					2'd0:    hit_kind <= KIND_EMPTY;
					2'd1:    hit_kind <= KIND_WALL;
					2'd2:    hit_kind <= KIND_DESTROY;
					default: hit_kind <= KIND_SOLID;
				endcase
			end
		end
	end
endmodule

>>> rtl/gdda_ctrl.sv
module gdda_ctrl import gdda_pkg::*; #(
	parameter int MAP_DIM = MAP_DIM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       operation,
	output logic       busy,
	output logic       valid,
	output gdda_cmd_t  cmd,
	input  gdda_stat_t stat
);
	localparam int IW = 2 * $clog2(MAP_DIM);

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DIV, S_MULX, S_MULY, S_STEP, S_READ, S_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] n_q;
	logic [IW:0]      clr_q;
	logic             accept;

	assign accept = start && !busy;
	assign busy   = state_q != S_IDLE;

	always_comb begin
		cmd = '0;
		cmd.load      = accept && operation == OP_CAST;
		cmd.wr_item   = accept && operation == OP_WRITE;
		cmd.div_start = cmd.load;
		cmd.clr_sweep = state_q == S_CLEAR;
		cmd.div_step  = state_q == S_DIV;
		cmd.mul_x     = state_q == S_MULX;
		cmd.mul_y     = state_q == S_MULY;
		cmd.advance   = state_q == S_STEP;
		cmd.emit      = state_q == S_EMIT;
		cmd.emit_last = stat.outside || stat.tile_code != 2'd0 ||
			n_q == CNT_W'(RESULT_CAP - 1);
		cmd.clr_tile  = state_q == S_EMIT && !stat.outside && stat.tile_code == 2'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			n_q     <= '0;
			clr_q   <= '0;
			valid   <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (IW+1)'((1 << IW) - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (cmd.load) begin
					n_q     <= '0;
					state_q <= S_DIV;
				end
				S_DIV:  if (stat.div_done) state_q <= S_MULX;
				S_MULX: state_q <= S_MULY;
				S_MULY: state_q <= S_STEP;
				S_STEP: state_q <= S_READ;
				S_READ: state_q <= S_EMIT;
				S_EMIT: begin
					valid <= 1'b1;
					n_q   <= n_q + 1'b1;
					state_q <= cmd.emit_last ? S_IDLE : S_STEP;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/grid_dda_ray_traversal.sv
// Grid ray walker. Write items (operation 0) store one tile. Cast items
// (operation 1) run setup after acceptance on the shared one-bit-a-cycle
// reciprocal unit, x then y, and two setup multiplies, then go through
// step, registered map read and result for each cell entered, up to 64
// results. Each result shows for one cycle with valid high; the receiver
// cannot stall. busy stays high from acceptance until the cycle of the
// final result. After reset all 2**(2*clog2(MAP_DIM)) map entries (1024
// for a 32 by 32 map) are cleared, one entry a cycle, during which busy
// is high.
module grid_dda_ray_traversal import gdda_pkg::*; #(
	parameter int MAP_DIM   = MAP_DIM_DEF,
	parameter int TILE_BITS = TILE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               valid,
	input  logic               operation,
	input  logic [4:0]         tile_x,
	input  logic [4:0]         tile_y,
	input  logic [7:0]         tile_value,
	input  logic [20:0]        pos_x,
	input  logic [20:0]        pos_y,
	input  logic signed [17:0] dir_x,
	input  logic signed [17:0] dir_y,
	output logic signed [6:0]  cell_x,
	output logic signed [6:0]  cell_y,
	output logic [2:0]         hit_kind,
	output logic               last
);
	gdda_cmd_t  cmd;
	gdda_stat_t stat;

	gdda_ctrl #(.MAP_DIM(MAP_DIM)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(operation),
		.busy(busy), .valid(valid), .cmd(cmd), .stat(stat)
	);

	gdda_datapath #(.MAP_DIM(MAP_DIM), .TILE_BITS(TILE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.tile_x(tile_x), .tile_y(tile_y), .tile_value(tile_value),
		.pos_x(pos_x), .pos_y(pos_y), .dir_x(dir_x), .dir_y(dir_y),
		.cell_x(cell_x), .cell_y(cell_y), .hit_kind(hit_kind), .last(last)
	);
endmodule

>>> rtl/gdda_checker.sv
module gdda_checker import gdda_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       busy,
	input logic       valid,
	input logic [2:0] hit_kind,
	input logic       last
);
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy)) else $error("result without busy");
	a_exit_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && hit_kind == KIND_EXIT |-> last) else $error("exit not last");
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> hit_kind <= KIND_EXIT) else $error("bad kind");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |-> !busy) else $error("busy after last");
endmodule

bind grid_dda_ray_traversal gdda_checker u_chk (
	.clk(clk), .arst_n(arst_n), .busy(busy), .valid(valid),
	.hit_kind(hit_kind), .last(last)
);
